// ===== src/bmmd_pkg.sv =====
// shared types and constants of the block mean motion detector
package bmmd_pkg;

  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;
  localparam int FW_W    = 12;
  localparam int THR_W   = 8;
  localparam int CNT_W   = 7;
  localparam int LUMA_W  = 8;
  localparam int MEAN_W  = 8;

  localparam logic [FW_W-1:0]  WIDTH_RST  = 12'd640;
  localparam logic [FW_W-1:0]  HEIGHT_RST = 12'd480;
  localparam logic [THR_W-1:0] THR_RST    = 8'd16;
  localparam logic [CNT_W-1:0] MIN_RST    = 7'd8;
  localparam logic [CNT_W-1:0] CNT_MAX    = {CNT_W{1'b1}};

  // geometry pipeline depth after a register write
  localparam int SETTLE_CNT_W = 2;
  localparam logic [SETTLE_CNT_W-1:0] SETTLE_LAST = 2'd2;

  typedef enum logic [1:0] {
    REG_WIDTH      = 2'd0,
    REG_HEIGHT     = 2'd1,
    REG_THRESH     = 2'd2,
    REG_MIN_BLOCKS = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_SETTLE,
    ST_LOCATE,
    ST_IDLE,
    ST_DIV,
    ST_CMP,
    ST_EMIT
  } ctrl_state_t;

  typedef struct packed {
    logic accept;
    logic loc_load;
    logic loc_step;
    logic cmp;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic blk_end;
    logic frame_end;
    logic loc_done;
    logic div_done;
    logic out_free;
  } dp_status_t;

endpackage

// ===== src/bmmd_div.sv =====
// restoring serial divider, one quotient bit per cycle
module bmmd_div import bmmd_pkg::*; #(
  parameter int DVD_W = 30,
  parameter int DSR_W = 22
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DSR_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int DC_W = (DVD_W > 1) ? $clog2(DVD_W) : 1;
  localparam logic [DC_W-1:0] LAST = DC_W'(DVD_W - 1);

  logic             busy;
  logic [DC_W-1:0]  cnt;
  logic [DVD_W-1:0] quo;
  logic [DSR_W-1:0] rem;
  logic [DSR_W-1:0] dsr;
  logic [DSR_W:0]   trial;
  logic             q_bit;
  logic [DSR_W-1:0] rem_next;

  always_comb begin
    trial    = {rem, quo[DVD_W-1]};
    q_bit    = trial >= {1'b0, dsr};
    rem_next = q_bit ? DSR_W'(trial - {1'b0, dsr}) : DSR_W'(trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // dividend bits shift out at the top while quotient bits shift in below
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      rem <= rem_next;
      quo <= {quo[DVD_W-2:0], q_bit};
    end
  end

  assign quotient = quo;

endmodule

// ===== src/bmmd_regs.sv =====
// register file on the apb port and the derived block geometry
module bmmd_regs import bmmd_pkg::*; #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048,
  parameter int GRID_COLS  = 8,
  parameter int GRID_ROWS  = 8,
  parameter int WCL_W      = 12,
  parameter int HCL_W      = 12,
  parameter int BW_W       = 9,
  parameter int BH_W       = 9,
  parameter int PIX_W      = 18
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output logic              cfg_wr,
  output logic [WCL_W-1:0]  w_cl,
  output logic [HCL_W-1:0]  h_cl,
  output logic [BW_W-1:0]   bw,
  output logic [BH_W-1:0]   bh,
  output logic [PIX_W-1:0]  blk_pix,
  output logic [THR_W-1:0]  thr,
  output logic [CNT_W-1:0]  min_blocks
);

  // reciprocals for the divide by grid size, exact over the whole clamp range
  localparam int W_SH = WCL_W + $clog2(GRID_COLS);
  localparam int H_SH = HCL_W + $clog2(GRID_ROWS);
  localparam int WR_W = W_SH + 1;
  localparam int HR_W = H_SH + 1;
  localparam longint unsigned W_RECIP_L = (64'd1 << W_SH) / GRID_COLS + 1;
  localparam longint unsigned H_RECIP_L = (64'd1 << H_SH) / GRID_ROWS + 1;
  localparam logic [WR_W-1:0] W_RECIP = WR_W'(W_RECIP_L);
  localparam logic [HR_W-1:0] H_RECIP = HR_W'(H_RECIP_L);
  localparam int WP_W = WCL_W + WR_W;
  localparam int HP_W = HCL_W + HR_W;

  reg_idx_t         ridx;
  logic [FW_W-1:0]  frame_width;
  logic [FW_W-1:0]  frame_height;
  logic [WCL_W-1:0] w_cl_next;
  logic [HCL_W-1:0] h_cl_next;
  logic [WP_W-1:0]  w_prod;
  logic [HP_W-1:0]  h_prod;

  assign ridx   = reg_idx_t'(paddr[3:2]);
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= WIDTH_RST;
      frame_height <= HEIGHT_RST;
      thr          <= THR_RST;
      min_blocks   <= MIN_RST;
    end else if (cfg_wr) begin
      unique case (ridx)
        REG_WIDTH:      frame_width  <= pwdata[FW_W-1:0];
        REG_HEIGHT:     frame_height <= pwdata[FW_W-1:0];
        REG_THRESH:     thr          <= pwdata[THR_W-1:0];
        REG_MIN_BLOCKS: min_blocks   <= pwdata[CNT_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      REG_WIDTH:      prdata = DATA_W'(frame_width);
      REG_HEIGHT:     prdata = DATA_W'(frame_height);
      REG_THRESH:     prdata = DATA_W'(thr);
      REG_MIN_BLOCKS: prdata = DATA_W'(min_blocks);
    endcase
  end

  always_comb begin
    priority if (32'(frame_width) < GRID_COLS) w_cl_next = WCL_W'(GRID_COLS);
    else if (32'(frame_width) > MAX_WIDTH)     w_cl_next = WCL_W'(MAX_WIDTH);
    else                                       w_cl_next = WCL_W'(frame_width);
    priority if (32'(frame_height) < GRID_ROWS) h_cl_next = HCL_W'(GRID_ROWS);
    else if (32'(frame_height) > MAX_HEIGHT)    h_cl_next = HCL_W'(MAX_HEIGHT);
    else                                        h_cl_next = HCL_W'(frame_height);
  end

  assign w_prod = WP_W'(w_cl) * WP_W'(W_RECIP);
  assign h_prod = HP_W'(h_cl) * HP_W'(H_RECIP);

  // three register stages: clamp, block size, block pixel count
  always_ff @(posedge clk) begin
    w_cl    <= w_cl_next;
    h_cl    <= h_cl_next;
    bw      <= BW_W'(w_prod >> W_SH);
    bh      <= BH_W'(h_prod >> H_SH);
    blk_pix <= PIX_W'(bw) * PIX_W'(bh);
  end

endmodule

// ===== src/bmmd_ctrl.sv =====
// sequencing state machine of the motion detector
module bmmd_ctrl import bmmd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  ctrl_state_t             state;
  ctrl_state_t             state_next;
  logic [SETTLE_CNT_W-1:0] settle_cnt;
  logic                    frame_pend;
  logic                    cfg_pend;
  logic                    resettle;

  assign resettle = cfg_wr | cfg_pend;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_SETTLE: begin
        if (!cfg_wr && settle_cnt == SETTLE_LAST) state_next = ST_LOCATE;
      end
      ST_LOCATE: begin
        if (cfg_wr)               state_next = ST_SETTLE;
        else if (status.loc_done) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (cfg_pend)                state_next = ST_SETTLE;
        else if (in_valid) begin
          if (status.blk_end)        state_next = ST_DIV;
          else if (status.frame_end) state_next = ST_EMIT;
        end else if (cfg_wr)         state_next = ST_SETTLE;
      end
      ST_DIV: begin
        if (status.div_done) state_next = ST_CMP;
      end
      ST_CMP: begin
        if (frame_pend)    state_next = ST_EMIT;
        else if (resettle) state_next = ST_SETTLE;
        else               state_next = ST_IDLE;
      end
      ST_EMIT: begin
        if (status.out_free) state_next = resettle ? ST_SETTLE : ST_IDLE;
      end
      default: state_next = ST_SETTLE;
    endcase
  end

  always_comb begin
    in_ready     = (state == ST_IDLE) && !cfg_pend;
    cmd.accept   = in_ready && in_valid;
    cmd.loc_load = (state == ST_SETTLE);
    cmd.loc_step = (state == ST_LOCATE);
    cmd.cmp      = (state == ST_CMP);
    cmd.emit     = (state == ST_EMIT) && status.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_SETTLE;
      settle_cnt <= '0;
      frame_pend <= 1'b0;
      cfg_pend   <= 1'b0;
    end else begin
      state <= state_next;
      if (state != ST_SETTLE || cfg_wr) settle_cnt <= '0;
      else                              settle_cnt <= settle_cnt + 1'b1;
      if (cmd.accept) frame_pend <= status.frame_end;
      // a write landing mid-item reruns the geometry settle afterwards
      cfg_pend <= (state_next == ST_SETTLE) ? 1'b0 : resettle;
    end
  end

endmodule

// ===== src/bmmd_dp.sv =====
// pixel position, band sums, mean store and result register
module bmmd_dp import bmmd_pkg::*; #(
  parameter int GRID_COLS   = 8,
  parameter int GRID_ROWS   = 8,
  parameter int SKIP_FRAMES = 1,
  parameter int WCL_W       = 12,
  parameter int HCL_W       = 12,
  parameter int COL_W       = 11,
  parameter int ROW_W       = 11,
  parameter int BW_W        = 9,
  parameter int BH_W        = 9,
  parameter int PIX_W       = 18,
  parameter int SUM_W       = 30
) (
  input  logic              clk,
  input  logic              rst,
  input  dp_cmd_t           cmd,
  output dp_status_t        status,
  input  logic [LUMA_W-1:0] luma,
  input  logic [WCL_W-1:0]  w_cl,
  input  logic [HCL_W-1:0]  h_cl,
  input  logic [BW_W-1:0]   bw,
  input  logic [BH_W-1:0]   bh,
  input  logic [PIX_W-1:0]  blk_pix,
  input  logic [THR_W-1:0]  thr,
  input  logic [CNT_W-1:0]  min_blocks,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CNT_W-1:0]  changed_blocks,
  output logic              motion
);

  localparam int BC_W  = $clog2(GRID_COLS + 1);
  localparam int BR_W  = $clog2(GRID_ROWS + 1);
  localparam int BCI_W = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
  localparam int NBLK  = GRID_COLS * GRID_ROWS;
  localparam int IDX_W = (NBLK > 1) ? $clog2(NBLK) : 1;
  localparam int FS_W  = $clog2(SKIP_FRAMES + 2);
  localparam logic [FS_W-1:0] FS_ARMED = FS_W'(SKIP_FRAMES + 1);

  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  row;
  logic [WCL_W-1:0]  sub_col;
  logic [HCL_W-1:0]  sub_row;
  logic [BC_W-1:0]   bc;
  logic [BR_W-1:0]   br;
  logic [SUM_W-1:0]  band_sums [GRID_COLS];
  logic [IDX_W-1:0]  idx;
  logic [MEAN_W-1:0] mean_mem [NBLK];
  logic [NBLK-1:0]   mean_vld;
  logic [MEAN_W-1:0] old_rd;
  logic [CNT_W-1:0]  cnt;
  logic [FS_W-1:0]   frames_seen;

  logic              in_col;
  logic              in_row;
  logic              in_grid;
  logic              col_more;
  logic              row_more;
  logic              scol_last;
  logic              srow_last;
  logic              row_end;
  logic              frame_end;
  logic              blk_end;
  logic [BCI_W-1:0]  bci;
  logic [SUM_W-1:0]  blk_sum;
  logic [IDX_W-1:0]  idx_next;
  logic              div_done;
  logic [SUM_W-1:0]  mean;
  logic [SUM_W-1:0]  old_x;
  logic [SUM_W-1:0]  diff;
  logic              changed;

  always_comb begin
    in_col    = bc < BC_W'(GRID_COLS);
    in_row    = br < BR_W'(GRID_ROWS);
    in_grid   = in_col && in_row;
    col_more  = in_col && (sub_col >= WCL_W'(bw));
    row_more  = in_row && (sub_row >= HCL_W'(bh));
    scol_last = sub_col == WCL_W'(bw) - WCL_W'(1);
    srow_last = sub_row == HCL_W'(bh) - HCL_W'(1);
    row_end   = WCL_W'(col) >= w_cl - WCL_W'(1);
    frame_end = row_end && (HCL_W'(row) >= h_cl - HCL_W'(1));
    blk_end   = in_grid && scol_last && srow_last;
    bci       = bc[BCI_W-1:0];
    blk_sum   = band_sums[bci] + SUM_W'(luma);
    idx_next  = IDX_W'(int'(br) * GRID_COLS + int'(bc));
  end

  // position tracking, and the walk that rebuilds block coordinates after a write
  always_ff @(posedge clk) begin
    if (rst) begin
      col     <= '0;
      row     <= '0;
      sub_col <= '0;
      sub_row <= '0;
      bc      <= '0;
      br      <= '0;
    end else if (cmd.loc_load) begin
      sub_col <= WCL_W'(col);
      sub_row <= HCL_W'(row);
      bc      <= '0;
      br      <= '0;
    end else if (cmd.loc_step) begin
      if (col_more) begin
        sub_col <= sub_col - WCL_W'(bw);
        bc      <= bc + 1'b1;
      end
      if (row_more) begin
        sub_row <= sub_row - HCL_W'(bh);
        br      <= br + 1'b1;
      end
    end else if (cmd.accept) begin
      if (frame_end) begin
        col     <= '0;
        row     <= '0;
        sub_col <= '0;
        sub_row <= '0;
        bc      <= '0;
        br      <= '0;
      end else if (row_end) begin
        col     <= '0;
        sub_col <= '0;
        bc      <= '0;
        row     <= row + 1'b1;
        if (in_row) begin
          if (srow_last) begin
            sub_row <= '0;
            br      <= br + 1'b1;
          end else begin
            sub_row <= sub_row + 1'b1;
          end
        end
      end else begin
        col <= col + 1'b1;
        if (in_col) begin
          if (scol_last) begin
            sub_col <= '0;
            bc      <= bc + 1'b1;
          end else begin
            sub_col <= sub_col + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < GRID_COLS; i++) band_sums[i] <= '0;
    end else if (cmd.accept) begin
      priority if (frame_end) begin
        for (int i = 0; i < GRID_COLS; i++) band_sums[i] <= '0;
      end else if (blk_end) begin
        band_sums[bci] <= '0;
      end else if (in_grid) begin
        band_sums[bci] <= blk_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && blk_end) idx <= idx_next;
  end

  bmmd_div #(
    .DVD_W (SUM_W),
    .DSR_W (PIX_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.accept && blk_end),
    .dividend (blk_sum),
    .divisor  (blk_pix),
    .done     (div_done),
    .quotient (mean)
  );

  // previous block means; entries never written read as zero
  always_ff @(posedge clk) begin
    old_rd <= mean_mem[idx];
    if (cmd.cmp) mean_mem[idx] <= mean[MEAN_W-1:0];
  end

  always_comb begin
    old_x   = mean_vld[idx] ? SUM_W'(old_rd) : '0;
    diff    = (mean > old_x) ? mean - old_x : old_x - mean;
    changed = diff >= SUM_W'(thr);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mean_vld    <= '0;
      cnt         <= '0;
      frames_seen <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.cmp) begin
        mean_vld[idx] <= 1'b1;
        if (changed && cnt != CNT_MAX) cnt <= cnt + 1'b1;
      end
      if (cmd.emit) begin
        cnt       <= '0;
        out_valid <= 1'b1;
        if (frames_seen < FS_ARMED) frames_seen <= frames_seen + 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      changed_blocks <= cnt;
      motion         <= (frames_seen == FS_ARMED) && (cnt >= min_blocks);
    end
  end

  always_comb begin
    status.blk_end   = blk_end;
    status.frame_end = frame_end;
    status.loc_done  = !col_more && !row_more;
    status.div_done  = div_done;
    status.out_free  = !out_valid || out_ready;
  end

endmodule

// ===== src/block_mean_motion_detector.sv =====
// block mean motion detector: luma stream in, per-frame changed block count out
// throughput one pixel per cycle while in_ready is high; a block's last pixel stalls
// input while the serial mean divider (SUM_W = 30 by default) and the compare run
// a frame's last pixel stalls input for the emit, longer while the result word is not taken
// after reset or a register write, input stalls while the geometry settles and
// block coordinates are rebuilt
module block_mean_motion_detector import bmmd_pkg::*; #(
  parameter int MAX_WIDTH   = 2048,
  parameter int MAX_HEIGHT  = 2048,
  parameter int GRID_COLS   = 8,
  parameter int GRID_ROWS   = 8,
  parameter int SKIP_FRAMES = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [LUMA_W-1:0] luma,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CNT_W-1:0]  changed_blocks,
  output logic              motion
);

  localparam int WCL_W = $clog2(MAX_WIDTH + 1);
  localparam int HCL_W = $clog2(MAX_HEIGHT + 1);
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int BW_W  = $clog2(MAX_WIDTH / GRID_COLS + 1);
  localparam int BH_W  = $clog2(MAX_HEIGHT / GRID_ROWS + 1);
  localparam int PIX_W = BW_W + BH_W;
  localparam int SUM_W = $clog2(MAX_WIDTH) + $clog2(MAX_HEIGHT) + LUMA_W;

  logic             cfg_wr;
  logic [WCL_W-1:0] w_cl;
  logic [HCL_W-1:0] h_cl;
  logic [BW_W-1:0]  bw;
  logic [BH_W-1:0]  bh;
  logic [PIX_W-1:0] blk_pix;
  logic [THR_W-1:0] thr;
  logic [CNT_W-1:0] min_blocks;
  dp_cmd_t          cmd;
  dp_status_t       status;

  bmmd_regs #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .GRID_COLS  (GRID_COLS),
    .GRID_ROWS  (GRID_ROWS),
    .WCL_W      (WCL_W),
    .HCL_W      (HCL_W),
    .BW_W       (BW_W),
    .BH_W       (BH_W),
    .PIX_W      (PIX_W)
  ) u_regs (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .cfg_wr     (cfg_wr),
    .w_cl       (w_cl),
    .h_cl       (h_cl),
    .bw         (bw),
    .bh         (bh),
    .blk_pix    (blk_pix),
    .thr        (thr),
    .min_blocks (min_blocks)
  );

  bmmd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cfg_wr   (cfg_wr),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  bmmd_dp #(
    .GRID_COLS   (GRID_COLS),
    .GRID_ROWS   (GRID_ROWS),
    .SKIP_FRAMES (SKIP_FRAMES),
    .WCL_W       (WCL_W),
    .HCL_W       (HCL_W),
    .COL_W       (COL_W),
    .ROW_W       (ROW_W),
    .BW_W        (BW_W),
    .BH_W        (BH_W),
    .PIX_W       (PIX_W),
    .SUM_W       (SUM_W)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .luma           (luma),
    .w_cl           (w_cl),
    .h_cl           (h_cl),
    .bw             (bw),
    .bh             (bh),
    .blk_pix        (blk_pix),
    .thr            (thr),
    .min_blocks     (min_blocks),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .changed_blocks (changed_blocks),
    .motion         (motion)
  );

  a_out_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.emit))
    else $error("result word appeared without an emit");

  a_blk_end_stalls: assert property (@(posedge clk) disable iff (rst)
    cmd.accept && status.blk_end |=> !in_ready)
    else $error("input taken while a block mean is pending");

  a_frame_end_stalls: assert property (@(posedge clk) disable iff (rst)
    cmd.accept && status.frame_end |=> !in_ready)
    else $error("input taken before the frame result was issued");

endmodule
